[src/slpg_pkg.sv]
// Shared types, codes and constants of the status LED pattern generator.
package slpg_pkg;

   localparam int PATTERN_W   = 3;
   localparam int COLOR_W     = 8;
   localparam int PERIOD_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COLOR_W-1:0]  BRIGHTNESS_RESET   = 8'd255;
   localparam logic [PERIOD_W-1:0] RAINBOW_STEP_RESET = 16'd15;
   localparam logic [PERIOD_W-1:0] RED_HALF_RESET     = 16'd300;
   localparam logic [PERIOD_W-1:0] CYAN_HALF_RESET    = 16'd150;

   localparam logic [COLOR_W-1:0] COLOR_FULL  = 8'hFF;
   localparam logic [COLOR_W-1:0] WHEEL_SEG_1 = 8'd85;
   localparam logic [COLOR_W-1:0] WHEEL_SEG_2 = 8'd170;

   typedef enum logic [PATTERN_W-1:0] {
      PAT_OFF     = 3'd0,
      PAT_GREEN   = 3'd1,
      PAT_RED     = 3'd2,
      PAT_CYAN    = 3'd3,
      PAT_RAINBOW = 3'd4
   } pattern_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_SET  = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHTNESS   = 2'd0,
      CSR_RAINBOW_STEP = 2'd1,
      CSR_RED_HALF     = 2'd2,
      CSR_CYAN_HALF    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  brightness;
      logic [PERIOD_W-1:0] rainbow_step_ms;
      logic [PERIOD_W-1:0] red_half_period_ms;
      logic [PERIOD_W-1:0] cyan_half_period_ms;
   } cfg_type;

   typedef struct packed {
      logic                mode;
      logic [PATTERN_W-1:0] pattern;
   } item_type;

   typedef struct packed {
      logic               led_off;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] level;
   } color_type;

   typedef struct packed {
      logic      valid;
      color_type color;
   } result_type;

endpackage

[src/slpg_req_if.sv]
// Request channel: tick or pattern select beats.
interface slpg_req_if
   import slpg_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [PATTERN_W-1:0] pattern;

   modport source (output valid, output mode, output pattern, input ready);
   modport sink   (input valid, input mode, input pattern, output ready);
endinterface

[src/slpg_rsp_if.sv]
// Response channel: LED color beats.
interface slpg_rsp_if
   import slpg_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               led_off;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic [COLOR_W-1:0] level;

   modport source (output valid, output led_off, output red, output green, output blue,
                   output level, input ready);
   modport sink   (input valid, input led_off, input red, input green, input blue,
                   input level, output ready);
endinterface

[src/slpg_csr.sv]
// Configuration register file of the status LED pattern generator.
module slpg_csr
   import slpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BRIGHTNESS:   cfg_in.brightness          = csr_wdata[COLOR_W-1:0];
            CSR_RAINBOW_STEP: cfg_in.rainbow_step_ms     = csr_wdata[PERIOD_W-1:0];
            CSR_RED_HALF:     cfg_in.red_half_period_ms  = csr_wdata[PERIOD_W-1:0];
            CSR_CYAN_HALF:    cfg_in.cyan_half_period_ms = csr_wdata[PERIOD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness          <= BRIGHTNESS_RESET;
         cfg_ff.rainbow_step_ms     <= RAINBOW_STEP_RESET;
         cfg_ff.red_half_period_ms  <= RED_HALF_RESET;
         cfg_ff.cyan_half_period_ms <= CYAN_HALF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/slpg_update.sv]
// Pattern state and single-pass update logic: one item in, at most one color out.
module slpg_update
   import slpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   pattern_type         pattern_ff, pattern_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic                pending_ff, pending_in;
   logic [COLOR_W-1:0]  phase_ff, phase_in;
   logic                blink_ff, blink_in;

   logic [PERIOD_W-1:0] elapsed_inc;
   logic [PERIOD_W-1:0] period;
   logic                animated;

   // Three-segment color wheel; each segment ramps one channel up and one down.
   function automatic color_type wheel(input logic [COLOR_W-1:0] pos,
                                       input logic [COLOR_W-1:0] lvl);
      color_type             c;
      logic [COLOR_W-1:0]    ofs;
      logic [COLOR_W+1:0]    ramp_wide;
      logic [COLOR_W-1:0]    ramp;
      c         = '0;
      c.level   = lvl;
      if (pos < WHEEL_SEG_1) begin
         ofs = pos;
      end else if (pos < WHEEL_SEG_2) begin
         ofs = pos - WHEEL_SEG_1;
      end else begin
         ofs = pos - WHEEL_SEG_2;
      end
      ramp_wide = {2'b00, ofs} + {1'b0, ofs, 1'b0};
      ramp      = ramp_wide[COLOR_W-1:0];
      if (pos < WHEEL_SEG_1) begin
         c.red   = ramp;
         c.green = COLOR_FULL - ramp;
      end else if (pos < WHEEL_SEG_2) begin
         c.red  = COLOR_FULL - ramp;
         c.blue = ramp;
      end else begin
         c.green = ramp;
         c.blue  = COLOR_FULL - ramp;
      end
      return c;
   endfunction

   always_comb begin
      pattern_in = pattern_ff;
      elapsed_in = elapsed_ff;
      pending_in = pending_ff;
      phase_in   = phase_ff;
      blink_in   = blink_ff;
      result     = '0;

      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

      animated = 1'b1;
      case (pattern_ff)
         PAT_RAINBOW: period = cfg.rainbow_step_ms;
         PAT_RED:     period = cfg.red_half_period_ms;
         PAT_CYAN:    period = cfg.cyan_half_period_ms;
         default: begin
            period   = '0;
            animated = 1'b0;
         end
      endcase

      if (item.mode == MODE_SET) begin
         // Drop unknown codes and repeats of the running pattern.
         if (item.pattern <= PATTERN_W'(PAT_RAINBOW) && item.pattern != PATTERN_W'(pattern_ff)) begin
            pattern_in = pattern_type'(item.pattern);
            elapsed_in = '0;
            pending_in = 1'b1;
            phase_in   = '0;
            blink_in   = 1'b0;
            result.color.level = cfg.brightness;
            unique case (pattern_type'(item.pattern))
               PAT_OFF: begin
                  result.valid         = 1'b1;
                  result.color.led_off = 1'b1;
                  result.color.level   = '0;
               end
               PAT_GREEN: begin
                  result.valid       = 1'b1;
                  result.color.green = COLOR_FULL;
               end
               PAT_RED: begin
                  result.valid     = 1'b1;
                  result.color.red = COLOR_FULL;
               end
               PAT_CYAN: begin
                  result.valid       = 1'b1;
                  result.color.green = COLOR_FULL;
                  result.color.blue  = COLOR_FULL;
               end
               default: result.valid = 1'b0;
            endcase
         end
      end else if (animated) begin
         if (pending_ff || elapsed_inc >= period) begin
            elapsed_in   = '0;
            pending_in   = 1'b0;
            result.valid = 1'b1;
            if (pattern_ff == PAT_RAINBOW) begin
               phase_in     = phase_ff + 1'b1;
               result.color = wheel(phase_ff + 1'b1, cfg.brightness);
            end else begin
               blink_in           = ~blink_ff;
               result.color.level = cfg.brightness;
               if (pattern_ff == PAT_RED) begin
                  result.color.red = {COLOR_W{~blink_ff}};
               end else begin
                  result.color.green = {COLOR_W{~blink_ff}};
                  result.color.blue  = {COLOR_W{~blink_ff}};
               end
            end
         end else begin
            elapsed_in = elapsed_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PAT_OFF;
         elapsed_ff <= '0;
         pending_ff <= 1'b1;
         phase_ff   <= '0;
         blink_ff   <= 1'b0;
      end else if (fire) begin
         pattern_ff <= pattern_in;
         elapsed_ff <= elapsed_in;
         pending_ff <= pending_in;
         phase_ff   <= phase_in;
         blink_ff   <= blink_in;
      end
   end

endmodule

[src/status_led_pattern_generator_unit.sv]
// Top level of the RGB status LED pattern generator.
// Each request beat is either a one-millisecond tick (mode 0) or a pattern
// select (mode 1: off, solid green, red blink, cyan blink, rainbow). A select
// of a new pattern restarts its timing and sends the new color at once
// (rainbow sends nothing until its first tick); repeats and unknown codes send
// nothing. Ticks drive the blink half periods and the rainbow wheel steps from
// the csr period registers, and the first tick after a change updates at once.
// A beat is registered on entry, updated in one pass through the pattern state
// and lands in the response register; between a request beat and its response
// beat lie the entry register and then the response register, and one beat is
// taken every cycle as long as the response side keeps up. While a response
// is stalled, one more request beat is held in the entry register before
// req_ch.ready drops. Brightness is copied into level on every color beat;
// an off beat carries zero color and zero level. Write the csr registers only
// while no beat is in flight.
module status_led_pattern_generator_unit
   import slpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   slpg_req_if.sink               req_ch,
   slpg_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;

   // Entry register.
   logic     in_valid_ff, in_valid_in;
   item_type item_ff;

   // Response register.
   logic      out_valid_ff, out_valid_in;
   color_type out_ff;

   logic req_beat;
   logic process;

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slpg_update u_update (
      .clock  (clock),
      .reset  (reset),
      .fire   (process),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Advance the held beat when the response register is empty or draining.
   assign process      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || process;
   assign req_beat     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (process) begin
         out_valid_in = result.valid;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: capture on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff.mode    <= req_ch.mode;
         item_ff.pattern <= req_ch.pattern;
      end
      if (process && result.valid) begin
         out_ff <= result.color;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.led_off = out_ff.led_off;
   assign rsp_ch.red     = out_ff.red;
   assign rsp_ch.green   = out_ff.green;
   assign rsp_ch.blue    = out_ff.blue;
   assign rsp_ch.level   = out_ff.level;

endmodule

[src/slpg_checker.sv]
// Port-level checks of the status LED pattern generator, bound to the top level.
module slpg_checker
   import slpg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_led_off,
   input logic [COLOR_W-1:0] rsp_red,
   input logic [COLOR_W-1:0] rsp_green,
   input logic [COLOR_W-1:0] rsp_blue,
   input logic [COLOR_W-1:0] rsp_level
);

   // No response beat right after reset.
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Off beats carry no color and no level.
   a_off_dark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_led_off |->
         rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && rsp_level == '0)
      else $error("off beat carries color");

   // Every pattern leaves at least one channel dark.
   a_one_dark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red == '0 || rsp_green == '0 || rsp_blue == '0)
      else $error("all three channels lit");

   // Hold a stalled response beat.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_off) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_level))
      else $error("stalled response beat changed");

endmodule

bind status_led_pattern_generator_unit slpg_checker u_slpg_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_led_off (rsp_ch.led_off),
   .rsp_red     (rsp_ch.red),
   .rsp_green   (rsp_ch.green),
   .rsp_blue    (rsp_ch.blue),
   .rsp_level   (rsp_ch.level)
);
